[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, switched off while reset is held
`define SST_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// concurrent check that also holds while reset is held
`define SST_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/sst_pkg.sv]
`default_nettype none

package sst_pkg;

    // default grid limits
    localparam int MAX_COLS_DEF = 1024;
    localparam int MAX_ROWS_DEF = 4096;

    // field widths
    localparam int SAMPLE_W    = 32;
    localparam int COEF_W      = 18;
    localparam int PACK_W      = 36;
    localparam int PROD_W      = SAMPLE_W + COEF_W;
    localparam int ACC_W       = PROD_W + 4;
    localparam int CFG_DATA_W  = 36;
    localparam int CFG_INDEX_W = 3;
    localparam int GRID_COLS_W = 11;
    localparam int GRID_ROWS_W = 13;

    // stencil shape
    localparam int RADIUS     = 2;
    localparam int NUM_TAPS   = 9;
    localparam int NUM_BANKS  = 4;
    localparam int BANK_SEL_W = 2;
    localparam int MIN_DIM    = 5;

    // register reset values
    localparam logic [GRID_COLS_W-1:0] GRID_COLS_RST = 11'd1024;
    localparam logic [GRID_ROWS_W-1:0] GRID_ROWS_RST = 13'd4096;
    localparam logic [COEF_W-1:0]      COEF_CENTER_RST = 18'h36000;
    localparam logic [PACK_W-1:0]      COEF_PACK_RST = 36'd68361672021;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GRID_COLS   = 3'd0,
        REG_GRID_ROWS   = 3'd1,
        REG_COEF_CENTER = 3'd2,
        REG_COEF_WEST   = 3'd3,
        REG_COEF_EAST   = 3'd4,
        REG_COEF_NORTH  = 3'd5,
        REG_COEF_SOUTH  = 3'd6
    } cfg_reg_t;

    // sideband that travels with each item down the cell chain
    typedef struct packed {
        logic valid;
        logic last;
    } chain_ctl_t;

endpackage

`default_nettype wire

[rtl/sst_line_bank.sv]
`default_nettype none

module sst_line_bank #(
    parameter int DEPTH  = sst_pkg::MAX_COLS_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire                             clk,
    input  wire                             wr_en,
    input  wire                             rd_en,
    input  wire        [ADDR_W-1:0]         addr,
    input  wire        [sst_pkg::SAMPLE_W-1:0] wr_data,
    output logic       [sst_pkg::SAMPLE_W-1:0] rd_data
);

    logic [sst_pkg::SAMPLE_W-1:0] mem [DEPTH];
    logic [sst_pkg::SAMPLE_W-1:0] rd_data_reg;

    // read returns the old word when the same address is written
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[rtl/sst_mac_cell.sv]
`default_nettype none

module sst_mac_cell #(
    parameter int DELAY = 0
) (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire                                    adv,
    input  wire  signed [sst_pkg::COEF_W-1:0]      coef,
    input  wire  signed [sst_pkg::SAMPLE_W-1:0]    tap,
    input  wire  signed [sst_pkg::ACC_W-1:0]       sum_in,
    input  sst_pkg::chain_ctl_t                    ctl_in,
    output logic signed [sst_pkg::ACC_W-1:0]       sum_out,
    output sst_pkg::chain_ctl_t                    ctl_out
);

    logic signed [sst_pkg::SAMPLE_W-1:0] tap_use;
    logic signed [sst_pkg::PROD_W-1:0]   prod_next;
    logic signed [sst_pkg::PROD_W-1:0]   prod_reg;
    logic signed [sst_pkg::ACC_W-1:0]    prod_ext;
    logic signed [sst_pkg::ACC_W-1:0]    sum_reg;
    sst_pkg::chain_ctl_t                 ctl_reg;

    // tap delay so the product meets the partial sum from the previous cell
    generate
        if (DELAY > 0)
        begin : g_delay
            logic signed [sst_pkg::SAMPLE_W-1:0] line_reg [DELAY];

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    line_reg[0] <= tap;
                    for (int i = 1; i < DELAY; i++)
                    begin
                        line_reg[i] <= line_reg[i-1];
                    end
                end
            end

            assign tap_use = line_reg[DELAY-1];
        end
        else
        begin : g_direct
            assign tap_use = tap;
        end
    endgenerate

    // product stage
    assign prod_next = coef * tap_use;
    assign prod_ext  = {{(sst_pkg::ACC_W - sst_pkg::PROD_W){prod_reg[sst_pkg::PROD_W-1]}},
                        prod_reg};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= prod_next;
            sum_reg  <= sum_in + prod_ext;
        end
    end

    // sideband follows the partial sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (adv)
        begin
            ctl_reg <= ctl_in;
        end
    end

    assign sum_out = sum_reg;
    assign ctl_out = ctl_reg;

endmodule

`default_nettype wire

[rtl/star_stencil_9pt_2d_top.sv]
// data path: bank read stage, tap registers, mac cell chain, then the output buffer
// throughput: one item per cycle, set by the single-port line banks and the mac cell chain
// the whole pipeline moves in step and halts only while the two-entry output buffer is full
// reset: rst_n async, active low; clears counters and valid flags, config registers to defaults
// line buffer contents are not cleared; the block accepts items from the first cycle after reset
`default_nettype none

module star_stencil_9pt_2d_top #(
    parameter int MAX_COLS = sst_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = sst_pkg::MAX_ROWS_DEF
) (
    input  wire                                         clk,
    input  wire                                         rst_n,
    input  wire                                         in_valid,
    output logic                                        in_ready,
    input  wire  signed [sst_pkg::SAMPLE_W-1:0]         sample_in,
    output logic                                        out_valid,
    input  wire                                         out_ready,
    output logic signed [sst_pkg::SAMPLE_W-1:0]         sample_out,
    output logic                                        frame_last,
    input  wire                                         cfg_wr_en,
    input  wire         [sst_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire         [sst_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int COLS_CW = (sst_pkg::GRID_COLS_W > $clog2(MAX_COLS + 1)) ?
                             sst_pkg::GRID_COLS_W : $clog2(MAX_COLS + 1);
    localparam int ROWS_CW = (sst_pkg::GRID_ROWS_W > $clog2(MAX_ROWS + 1)) ?
                             sst_pkg::GRID_ROWS_W : $clog2(MAX_ROWS + 1);
    localparam int SW = sst_pkg::SAMPLE_W;
    localparam int CW = sst_pkg::COEF_W;
    localparam int AW = sst_pkg::ACC_W;
    localparam int NT = sst_pkg::NUM_TAPS;
    localparam int NB = sst_pkg::NUM_BANKS;
    localparam int BSW = sst_pkg::BANK_SEL_W;
    localparam int FRAC_SHIFT = 14;
    localparam int ROUND_BIAS = 1 << (FRAC_SHIFT - 1);
    localparam int OB_DEPTH = 2;
    localparam int OB_CNT_W = $clog2(OB_DEPTH + 1);
    localparam int OB_PTR_W = $clog2(OB_DEPTH);
    localparam int SKIP = 2 * sst_pkg::RADIUS;

    // configuration registers
    logic [sst_pkg::GRID_COLS_W-1:0] grid_cols_reg;
    logic [sst_pkg::GRID_ROWS_W-1:0] grid_rows_reg;
    logic [CW-1:0]                   coef_center_reg;
    logic [sst_pkg::PACK_W-1:0]      coef_west_reg;
    logic [sst_pkg::PACK_W-1:0]      coef_east_reg;
    logic [sst_pkg::PACK_W-1:0]      coef_north_reg;
    logic [sst_pkg::PACK_W-1:0]      coef_south_reg;

    // position and flow control
    logic [COL_W-1:0]   col_cnt_reg;
    logic [COL_W-1:0]   col_cnt_next;
    logic [ROW_W-1:0]   row_cnt_reg;
    logic [ROW_W-1:0]   row_cnt_next;
    logic [COLS_CW-1:0] cols_eff;
    logic [ROWS_CW-1:0] rows_eff;
    logic               row_end;
    logic               frame_end;
    logic               emit;
    logic               adv;
    logic               accept;

    // line banks
    logic [SW-1:0]  bank_rd [NB];
    logic [BSW-1:0] col_sel [NB];
    logic signed [SW-1:0] col_v [NB];

    // stage after the bank read
    logic                 s1_valid_reg;
    logic                 s1_emit_reg;
    logic                 s1_last_reg;
    logic [BSW-1:0]       s1_phase_reg;
    logic signed [SW-1:0] s1_sample_reg;

    // centre window and vertical neighbour delay
    logic signed [SW-1:0] cw_reg  [5];
    logic signed [SW-1:0] vd0_reg [4];
    logic signed [SW-1:0] vd1_reg [4];

    // taps and coefficients for the cell chain
    logic signed [SW-1:0] tap_next [NT];
    logic signed [SW-1:0] tap_reg  [NT];
    logic signed [CW-1:0] coef     [NT];
    sst_pkg::chain_ctl_t  tap_ctl_reg;
    sst_pkg::chain_ctl_t  head_ctl_reg;
    logic signed [AW-1:0] chain_sum [NT+1];
    sst_pkg::chain_ctl_t  chain_ctl [NT+1];

    // rounding and saturation
    logic signed [AW-1:0] biased;
    logic signed [AW-1:0] shifted;
    logic signed [SW-1:0] result;
    logic [AW-SW:0]       upper;

    // output buffer
    logic signed [SW-1:0] ob_data_reg [OB_DEPTH];
    logic                 ob_last_reg [OB_DEPTH];
    logic [OB_PTR_W-1:0]  ob_wr_ptr_reg;
    logic [OB_PTR_W-1:0]  ob_rd_ptr_reg;
    logic [OB_CNT_W-1:0]  ob_count_reg;
    logic                 push;
    logic                 pop;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_cols_reg   <= sst_pkg::GRID_COLS_RST;
            grid_rows_reg   <= sst_pkg::GRID_ROWS_RST;
            coef_center_reg <= sst_pkg::COEF_CENTER_RST;
            coef_west_reg   <= sst_pkg::COEF_PACK_RST;
            coef_east_reg   <= sst_pkg::COEF_PACK_RST;
            coef_north_reg  <= sst_pkg::COEF_PACK_RST;
            coef_south_reg  <= sst_pkg::COEF_PACK_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (sst_pkg::cfg_reg_t'(cfg_index))
                sst_pkg::REG_GRID_COLS:
                    grid_cols_reg <= cfg_data[sst_pkg::GRID_COLS_W-1:0];
                sst_pkg::REG_GRID_ROWS:
                    grid_rows_reg <= cfg_data[sst_pkg::GRID_ROWS_W-1:0];
                sst_pkg::REG_COEF_CENTER:
                    coef_center_reg <= cfg_data[CW-1:0];
                sst_pkg::REG_COEF_WEST:
                    coef_west_reg <= cfg_data[sst_pkg::PACK_W-1:0];
                sst_pkg::REG_COEF_EAST:
                    coef_east_reg <= cfg_data[sst_pkg::PACK_W-1:0];
                sst_pkg::REG_COEF_NORTH:
                    coef_north_reg <= cfg_data[sst_pkg::PACK_W-1:0];
                sst_pkg::REG_COEF_SOUTH:
                    coef_south_reg <= cfg_data[sst_pkg::PACK_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // grid size clamped to the supported range
    always_comb
    begin
        cols_eff = COLS_CW'(grid_cols_reg);
        if (cols_eff < COLS_CW'(sst_pkg::MIN_DIM))
            cols_eff = COLS_CW'(sst_pkg::MIN_DIM);
        else if (cols_eff > COLS_CW'(MAX_COLS))
            cols_eff = COLS_CW'(MAX_COLS);
        rows_eff = ROWS_CW'(grid_rows_reg);
        if (rows_eff < ROWS_CW'(sst_pkg::MIN_DIM))
            rows_eff = ROWS_CW'(sst_pkg::MIN_DIM);
        else if (rows_eff > ROWS_CW'(MAX_ROWS))
            rows_eff = ROWS_CW'(MAX_ROWS);
    end

    // pipeline advances while the output buffer has room
    assign adv      = (ob_count_reg != OB_CNT_W'(OB_DEPTH));
    assign in_ready = adv;
    assign accept   = in_valid && adv;

    // raster position
    assign row_end   = COLS_CW'(col_cnt_reg) >= (cols_eff - COLS_CW'(1));
    assign frame_end = row_end && (ROWS_CW'(row_cnt_reg) >= (rows_eff - ROWS_CW'(1)));
    assign emit      = (row_cnt_reg >= ROW_W'(SKIP)) && (col_cnt_reg >= COL_W'(SKIP));

    always_comb
    begin
        col_cnt_next = col_cnt_reg + COL_W'(1);
        row_cnt_next = row_cnt_reg;
        if (frame_end)
        begin
            col_cnt_next = '0;
            row_cnt_next = '0;
        end
        else if (row_end)
        begin
            col_cnt_next = '0;
            row_cnt_next = row_cnt_reg + ROW_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else if (accept)
        begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    // four row banks, read at the current column, the oldest row overwritten
    generate
        for (genvar b = 0; b < NB; b++)
        begin : g_bank
            sst_line_bank #(
                .DEPTH  (MAX_COLS),
                .ADDR_W (COL_W)
            ) u_bank (
                .clk     (clk),
                .wr_en   (accept && (row_cnt_reg[BSW-1:0] == BSW'(b))),
                .rd_en   (accept),
                .addr    (col_cnt_reg),
                .wr_data (sample_in),
                .rd_data (bank_rd[b])
            );
        end
    endgenerate

    // item state alongside the bank read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_emit_reg   <= emit;
            s1_last_reg   <= frame_end;
            s1_phase_reg  <= row_cnt_reg[BSW-1:0];
            s1_sample_reg <= sample_in;
        end
    end

    // rows r-4 .. r-1 in order, by rotating from the current row phase
    always_comb
    begin
        for (int k = 0; k < NB; k++)
        begin
            col_sel[k] = s1_phase_reg + BSW'(k);
            col_v[k]   = bank_rd[col_sel[k]];
        end
    end

    // centre window and vertical delay shift once per item
    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg)
        begin
            for (int i = 0; i < 4; i++)
            begin
                cw_reg[i]  <= cw_reg[i+1];
                vd1_reg[i] <= vd0_reg[i];
            end
            cw_reg[4]  <= col_v[2];
            vd0_reg[0] <= col_v[0];
            vd0_reg[1] <= col_v[1];
            vd0_reg[2] <= col_v[3];
            vd0_reg[3] <= s1_sample_reg;
        end
    end

    // taps of the point two columns back
    always_comb
    begin
        tap_next[0] = cw_reg[3];
        tap_next[1] = cw_reg[2];
        tap_next[2] = cw_reg[1];
        tap_next[3] = cw_reg[4];
        tap_next[4] = col_v[2];
        tap_next[5] = vd1_reg[1];
        tap_next[6] = vd1_reg[0];
        tap_next[7] = vd1_reg[2];
        tap_next[8] = vd1_reg[3];
    end

    assign coef[0] = coef_center_reg;
    assign coef[1] = coef_west_reg[CW-1:0];
    assign coef[2] = coef_west_reg[2*CW-1:CW];
    assign coef[3] = coef_east_reg[CW-1:0];
    assign coef[4] = coef_east_reg[2*CW-1:CW];
    assign coef[5] = coef_north_reg[CW-1:0];
    assign coef[6] = coef_north_reg[2*CW-1:CW];
    assign coef[7] = coef_south_reg[CW-1:0];
    assign coef[8] = coef_south_reg[2*CW-1:CW];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < NT; k++)
            begin
                tap_reg[k] <= tap_next[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_ctl_reg  <= '0;
            head_ctl_reg <= '0;
        end
        else if (adv)
        begin
            tap_ctl_reg.valid <= s1_valid_reg && s1_emit_reg;
            tap_ctl_reg.last  <= s1_last_reg;
            head_ctl_reg      <= tap_ctl_reg;
        end
    end

    // multiply-accumulate chain, one weight per cell
    assign chain_sum[0] = '0;
    assign chain_ctl[0] = head_ctl_reg;

    generate
        for (genvar k = 0; k < NT; k++)
        begin : g_cell
            sst_mac_cell #(
                .DELAY (k)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .adv     (adv),
                .coef    (coef[k]),
                .tap     (tap_reg[k]),
                .sum_in  (chain_sum[k]),
                .ctl_in  (chain_ctl[k]),
                .sum_out (chain_sum[k+1]),
                .ctl_out (chain_ctl[k+1])
            );
        end
    endgenerate

    // round to nearest, ties upward, then saturate
    always_comb
    begin
        biased  = chain_sum[NT] + AW'(ROUND_BIAS);
        shifted = biased >>> FRAC_SHIFT;
        upper   = shifted[AW-1:SW-1];
        if ((upper == '0) || (upper == '1))
            result = shifted[SW-1:0];
        else if (shifted[AW-1])
            result = {1'b1, {(SW-1){1'b0}}};
        else
            result = {1'b0, {(SW-1){1'b1}}};
    end

    // two-entry output buffer
    assign push = adv && chain_ctl[NT].valid;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ob_data_reg[ob_wr_ptr_reg] <= result;
            ob_last_reg[ob_wr_ptr_reg] <= chain_ctl[NT].last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ob_wr_ptr_reg <= '0;
            ob_rd_ptr_reg <= '0;
            ob_count_reg  <= '0;
        end
        else
        begin
            if (push)
                ob_wr_ptr_reg <= ob_wr_ptr_reg + OB_PTR_W'(1);
            if (pop)
                ob_rd_ptr_reg <= ob_rd_ptr_reg + OB_PTR_W'(1);
            priority if (push && !pop)
                ob_count_reg <= ob_count_reg + OB_CNT_W'(1);
            else if (pop && !push)
                ob_count_reg <= ob_count_reg - OB_CNT_W'(1);
            else
                ob_count_reg <= ob_count_reg;
        end
    end

    assign out_valid  = (ob_count_reg != '0);
    assign sample_out = ob_data_reg[ob_rd_ptr_reg];
    assign frame_last = ob_last_reg[ob_rd_ptr_reg];

endmodule

`default_nettype wire

[rtl/sst_checker.sv]
`default_nettype none

`include "assert_macros.svh"

module sst_checker (
    input wire                              clk,
    input wire                              rst_n,
    input wire                              in_valid,
    input wire                              in_ready,
    input wire                              out_valid,
    input wire                              out_ready,
    input wire [sst_pkg::SAMPLE_W-1:0]      sample_out,
    input wire                              frame_last
);

    // a waiting result holds still
    `SST_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(frame_last), "result changed while stalled")

    // input is refused only when results are waiting
    `SST_ASSERT(a_stall_has_output, !in_ready |-> out_valid, "input stalled with no result waiting")

    // a full buffer stays full until a result is taken
    `SST_ASSERT(a_stall_holds, !in_ready && !out_ready |=> !in_ready, "stall released without a pop")

    // nothing leaves and input is open while reset is held
    `SST_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !out_valid && in_ready, "activity during reset")

    // an empty buffer cannot be full by the next cycle
    `SST_ASSERT(a_accept_open, in_valid && in_ready && !out_valid |=> in_ready, "input closed with empty buffer")

endmodule

bind star_stencil_9pt_2d_top sst_checker u_sst_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .frame_last (frame_last)
);

`default_nettype wire
